FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies consequence in the same cycle
`define GCLE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition in this cycle implies consequence in the next cycle
`define GCLE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/gcle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcle_pkg;

    localparam int MAX_IN_FEATURES  = 128;
    localparam int MAX_OUT_FEATURES = 64;
    localparam int DATA_WIDTH       = 16;

    localparam int FRAC_BITS = 8;
    localparam int AGG_W     = 40;
    localparam int PROD_W    = AGG_W + DATA_WIDTH;
    localparam int SUM_W     = 64;

    localparam int IN_IDX_W  = $clog2(MAX_IN_FEATURES);
    localparam int OUT_IDX_W = $clog2(MAX_OUT_FEATURES);
    localparam int WADDR_W   = IN_IDX_W + OUT_IDX_W;

    localparam int OPCODE_W    = 2;
    localparam int ROW_W       = 7;
    localparam int COL_W       = 6;
    localparam int FIDX_W      = 7;
    localparam int TAG_W       = 24;
    localparam int OUT_INDEX_W = 6;
    localparam int OUT_VALUE_W = DATA_WIDTH - 1;
    localparam int OUT_LIMIT   = 2 ** (DATA_WIDTH - 1) - 1;

    localparam int IN_USED_W  = 8;
    localparam int OUT_USED_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [IN_USED_W-1:0]  IN_USED_RST  = 8'd100;
    localparam logic [OUT_USED_W-1:0] OUT_USED_RST = 7'd47;

    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACC    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_USED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_USED = 1'b1;

    localparam logic signed [AGG_W-1:0] AGG_MAX = {1'b0, {(AGG_W-1){1'b1}}};
    localparam logic signed [AGG_W-1:0] AGG_MIN = {1'b1, {(AGG_W-1){1'b0}}};

    typedef struct packed {
        logic [OPCODE_W-1:0]          opcode;
        logic [ROW_W-1:0]             weight_row;
        logic [COL_W-1:0]             weight_col;
        logic signed [DATA_WIDTH-1:0] weight_value;
        logic signed [DATA_WIDTH-1:0] edge_weight;
        logic [FIDX_W-1:0]            feature_index;
        logic signed [DATA_WIDTH-1:0] feature_value;
        logic [TAG_W-1:0]             node_tag;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]       result_node;
        logic [OUT_INDEX_W-1:0] out_index;
        logic [OUT_VALUE_W-1:0] out_value;
        logic                   last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC_MUL,
        S_ACC_WR,
        S_FIN_RUN,
        S_FIN_DRAIN,
        S_FIN_OUT
    } t_state;

    typedef struct packed {
        logic                    wr_en;
        logic [IN_IDX_W-1:0]     wr_addr;
        logic signed [AGG_W-1:0] wr_data;
        logic [IN_IDX_W-1:0]     rd_addr;
        logic                    clear;
    } t_agg_cmd;

    typedef struct packed {
        logic                         wr_en;
        logic [WADDR_W-1:0]           wr_addr;
        logic signed [DATA_WIDTH-1:0] wr_data;
        logic [WADDR_W-1:0]           rd_addr;
    } t_wgt_cmd;

endpackage

`default_nettype wire

FILE: rtl/gcle_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gcle_in_if;
    import gcle_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gcle_out_if;
    import gcle_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/gcle_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module gcle_mul (
    input  logic                                  i_clk,
    input  logic signed [gcle_pkg::AGG_W-1:0]      i_a,
    input  logic signed [gcle_pkg::DATA_WIDTH-1:0] i_b,
    output logic signed [gcle_pkg::PROD_W-1:0]     o_p
);
    import gcle_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/gcle_agg_store.sv
`timescale 1ns / 1ps
`default_nettype none

module gcle_agg_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gcle_pkg::t_agg_cmd               i_cmd,
    output logic signed [gcle_pkg::AGG_W-1:0] o_rd_data
);
    import gcle_pkg::*;

    logic signed [AGG_W-1:0]    r_mem [MAX_IN_FEATURES];
    logic [MAX_IN_FEATURES-1:0] r_vld;
    logic signed [AGG_W-1:0]    r_rd;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd <= r_mem[i_cmd.rd_addr];
    end

    // entries not written since reset or the last clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_cmd.rd_addr];
            if (i_cmd.clear) begin
                r_vld <= '0;
            end else if (i_cmd.wr_en) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

`default_nettype wire

FILE: rtl/gcle_wgt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module gcle_wgt_store (
    input  logic                                  i_clk,
    input  gcle_pkg::t_wgt_cmd                     i_cmd,
    output logic signed [gcle_pkg::DATA_WIDTH-1:0] o_rd_data
);
    import gcle_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_mem [MAX_IN_FEATURES * MAX_OUT_FEATURES];
    logic signed [DATA_WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd <= r_mem[i_cmd.rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

FILE: rtl/graph_conv_layer_engine.sv
// Graph-convolution node engine.
// Requests arrive on i_in (valid/ready); results leave on o_out (valid/ready).
// Load request: writes one weight, ready again next cycle.
// Accumulate request: edge * feature added into one aggregate entry by the
// read-modify-write of the aggregate store through the multiplier.
// Finish request: for each used output feature the shared multiplier walks the
// used input features, one product per cycle, then the pipeline drains
// (S_FIN_DRAIN) and the result is presented (S_FIN_OUT), held while the
// receiver stalls. The last result carries last.
// The aggregate is cleared when the last result is taken (or at once when no
// output features are used), then i_in is ready again.
// i_in is not ready while any request is in progress. A stalled receiver holds
// the current result and the block waits with it.
// Reset (i_rst_n low, synchronous) zeroes the aggregate, sets in_features_used
// to 100 and out_features_used to 47. Weights are undefined until loaded.
// Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_data) must be made only when idle.
`timescale 1ns / 1ps
`default_nettype none

module graph_conv_layer_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gcle_in_if.sink                            i_in,
    gcle_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [gcle_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gcle_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gcle_pkg::*;

    t_state                       r_state, n_state;
    logic [IN_USED_W-1:0]         r_fi, n_fi;
    logic [OUT_USED_W-1:0]        r_fo, n_fo;
    logic                         r_v1, n_v1;
    logic                         r_v2;
    logic signed [SUM_W-1:0]      r_sum, n_sum;
    t_out_item                    r_out, n_out;
    logic [FIDX_W-1:0]            r_idx, n_idx;
    logic signed [DATA_WIDTH-1:0] r_edge, n_edge;
    logic signed [DATA_WIDTH-1:0] r_feat, n_feat;
    logic [TAG_W-1:0]             r_tag, n_tag;
    logic [IN_USED_W-1:0]         r_cfg_in;
    logic [OUT_USED_W-1:0]        r_cfg_out;

    logic [IN_USED_W-1:0]           in_used;
    logic [OUT_USED_W-1:0]          out_used;
    logic [OUT_USED_W-1:0]          fo_inc;
    t_agg_cmd                       agg_cmd;
    t_wgt_cmd                       wgt_cmd;
    logic signed [AGG_W-1:0]        agg_rd;
    logic signed [DATA_WIDTH-1:0]   wgt_rd;
    logic signed [AGG_W-1:0]        mul_a;
    logic signed [DATA_WIDTH-1:0]   mul_b;
    logic signed [PROD_W-1:0]       mul_p;
    logic signed [2*DATA_WIDTH-1:0] acc_prod;
    logic signed [2*DATA_WIDTH-1:0] acc_q8;
    logic signed [AGG_W:0]          acc_sum;
    logic signed [AGG_W-1:0]        acc_sat;
    logic signed [SUM_W-1:0]        sum_q;
    logic [OUT_VALUE_W-1:0]         fin_val;

    assign in_used  = (r_cfg_in > IN_USED_W'(MAX_IN_FEATURES)) ?
                      IN_USED_W'(MAX_IN_FEATURES) : r_cfg_in;
    assign out_used = (r_cfg_out > OUT_USED_W'(MAX_OUT_FEATURES)) ?
                      OUT_USED_W'(MAX_OUT_FEATURES) : r_cfg_out;
    assign fo_inc   = r_fo + OUT_USED_W'(1);

    assign mul_a = (r_state == S_ACC_MUL) ? AGG_W'(r_feat) : agg_rd;
    assign mul_b = (r_state == S_ACC_MUL) ? r_edge : wgt_rd;

    gcle_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    gcle_agg_store u_agg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (agg_cmd),
        .o_rd_data (agg_rd)
    );

    gcle_wgt_store u_wgt (
        .i_clk     (i_clk),
        .i_cmd     (wgt_cmd),
        .o_rd_data (wgt_rd)
    );

    // accumulate: floor product to Q.8, saturating add into the aggregate
    assign acc_prod = mul_p[2*DATA_WIDTH-1:0];
    assign acc_q8   = acc_prod >>> FRAC_BITS;
    assign acc_sum  = (AGG_W+1)'(agg_rd) + (AGG_W+1)'(acc_q8);

    always_comb begin
        if (acc_sum[AGG_W] != acc_sum[AGG_W-1]) begin
            acc_sat = acc_sum[AGG_W] ? AGG_MIN : AGG_MAX;
        end else begin
            acc_sat = acc_sum[AGG_W-1:0];
        end
    end

    // finish: floor to Q.8, ReLU, saturate
    assign sum_q = r_sum >>> FRAC_BITS;

    always_comb begin
        if (sum_q[SUM_W-1]) begin
            fin_val = '0;
        end else if (sum_q > SUM_W'(OUT_LIMIT)) begin
            fin_val = OUT_VALUE_W'(OUT_LIMIT);
        end else begin
            fin_val = sum_q[OUT_VALUE_W-1:0];
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = (r_state == S_FIN_OUT);
    assign o_out.payload = r_out;

    always_comb begin
        n_state = r_state;
        n_fi    = r_fi;
        n_fo    = r_fo;
        n_v1    = 1'b0;
        n_sum   = r_sum;
        n_out   = r_out;
        n_idx   = r_idx;
        n_edge  = r_edge;
        n_feat  = r_feat;
        n_tag   = r_tag;

        agg_cmd         = '0;
        agg_cmd.wr_addr = r_idx[IN_IDX_W-1:0];
        agg_cmd.wr_data = acc_sat;
        agg_cmd.rd_addr = r_idx[IN_IDX_W-1:0];

        wgt_cmd         = '0;
        wgt_cmd.wr_addr = {i_in.payload.weight_row[IN_IDX_W-1:0],
                           i_in.payload.weight_col[OUT_IDX_W-1:0]};
        wgt_cmd.wr_data = i_in.payload.weight_value;
        wgt_cmd.rd_addr = {r_fi[IN_IDX_W-1:0], r_fo[OUT_IDX_W-1:0]};

        if (r_v2) begin
            n_sum = r_sum + SUM_W'(mul_p);
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.payload.opcode)
                        OP_LOAD: begin
                            wgt_cmd.wr_en =
                                ((IN_USED_W+1)'(i_in.payload.weight_row)
                                    < (IN_USED_W+1)'(MAX_IN_FEATURES)) &&
                                ((OUT_USED_W+1)'(i_in.payload.weight_col)
                                    < (OUT_USED_W+1)'(MAX_OUT_FEATURES));
                        end
                        OP_ACC: begin
                            if ((IN_USED_W+1)'(i_in.payload.feature_index)
                                    < (IN_USED_W+1)'(MAX_IN_FEATURES)) begin
                                n_idx   = i_in.payload.feature_index;
                                n_edge  = i_in.payload.edge_weight;
                                n_feat  = i_in.payload.feature_value;
                                n_state = S_ACC_MUL;
                            end
                        end
                        OP_FINISH: begin
                            n_tag = i_in.payload.node_tag;
                            n_fi  = '0;
                            n_fo  = '0;
                            n_sum = '0;
                            if (out_used == '0) begin
                                agg_cmd.clear = 1'b1;
                            end else begin
                                n_state = S_FIN_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ACC_MUL: begin
                n_state = S_ACC_WR;
            end
            S_ACC_WR: begin
                agg_cmd.wr_en = 1'b1;
                n_state       = S_IDLE;
            end
            S_FIN_RUN: begin
                agg_cmd.rd_addr = r_fi[IN_IDX_W-1:0];
                if (r_fi == in_used) begin
                    n_state = S_FIN_DRAIN;
                end else begin
                    n_v1 = 1'b1;
                    n_fi = r_fi + IN_USED_W'(1);
                end
            end
            S_FIN_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_out.result_node = r_tag;
                    n_out.out_index   = r_fo[OUT_INDEX_W-1:0];
                    n_out.out_value   = fin_val;
                    n_out.last        = (fo_inc == out_used);
                    n_state           = S_FIN_OUT;
                end
            end
            S_FIN_OUT: begin
                if (o_out.ready) begin
                    if (r_out.last) begin
                        agg_cmd.clear = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_fo    = fo_inc;
                        n_fi    = '0;
                        n_sum   = '0;
                        n_state = S_FIN_RUN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_fi <= '0;
            r_fo <= '0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_fi <= n_fi;
            r_fo <= n_fo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_out  <= n_out;
        r_idx  <= n_idx;
        r_edge <= n_edge;
        r_feat <= n_feat;
        r_tag  <= n_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_in  <= IN_USED_RST;
            r_cfg_out <= OUT_USED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_USED: begin
                    r_cfg_in <= i_cfg_data[IN_USED_W-1:0];
                end
                CFG_OUT_USED: begin
                    r_cfg_out <= i_cfg_data[OUT_USED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gcle_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gcle_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [gcle_pkg::OPCODE_W-1:0] i_in_opcode,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input gcle_pkg::t_out_item           i_out_payload
);
    import gcle_pkg::*;

    `GCLE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload))
    `GCLE_ASSERT_IMP(a_no_req_with_result, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `GCLE_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_opcode == OP_ACC, !i_in_ready)
    `GCLE_ASSERT_NXT(a_more_results, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_payload.last, !i_in_ready && !i_out_valid)

endmodule

bind graph_conv_layer_engine gcle_checker u_gcle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_opcode   (i_in.payload.opcode),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire
